// ===== rtl/sha_pkg.sv =====
package sha_pkg;

    // Operation codes of an input item.
    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LENGTH_POS = 6'd56;

    // One entry of the queue between front and back.
    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
    } t_cmd;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== rtl/sha_if.sv =====
// Input channel: one byte or a finish request.
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] data_byte;
    modport source (output valid, output opcode, output data_byte, input ready);
    modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

// Output channel: one digest word.
interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;
    modport source (output valid, output digest_word, output word_index, output last,
                    input ready);
    modport sink   (input valid, input digest_word, input word_index, input last,
                     output ready);
endinterface

// ===== rtl/sha256_byte_hasher.sv =====
// Channel  Dir  Payload
// in_ch    in   opcode[0], data_byte[7:0]
// out_ch   out  digest_word[31:0], word_index[2:0], last
//
// An absorb item stores one byte; the 64th byte of a block also loads the schedule,
// runs all 64 rounds on the single round unit and adds the result into the hash.
// A finish item pads one byte per cycle, runs one or two blocks, then sends
// eight words, one per cycle while out_ch is ready.
// Reset is synchronous, active low, and restores the initial hash values.
// A two-entry queue takes up to two more input items while the core is busy.
module sha256_byte_hasher (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sha_in_if.sink    in_ch,
    sha_out_if.source out_ch
);
    logic          cmd_valid, cmd_pop;
    sha_pkg::t_cmd cmd;

    sha_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_pop(cmd_pop));

    sha_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(cmd_valid),
        .i_cmd(cmd), .o_cmd_pop(cmd_pop), .out_ch(out_ch));
endmodule

// ===== rtl/sha_front.sv =====
// Front part: takes input items into a two-entry queue for the back part.
module sha_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sha_in_if.sink         in_ch,
    output logic           o_cmd_valid,
    output sha_pkg::t_cmd  o_cmd,
    input  logic           i_cmd_pop
);
    sha_pkg::t_cmd r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          push;

    assign in_ch.ready = (r_cnt != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // Queue storage and pointers.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp].opcode    <= in_ch.opcode;
            r_q[r_wp].data_byte <= in_ch.data_byte;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_cmd_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_cmd_pop};
        end
    end

`ifndef SYNTH
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> o_cmd_valid) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !in_ch.ready) else $error("ready while full");
`endif
endmodule

// ===== rtl/sha_core.sv =====
// Back part: block buffer, padding sequencer, round engine and digest output.
module sha_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  sha_pkg::t_cmd  i_cmd,
    output logic           o_cmd_pop,
    sha_out_if.source      out_ch
);
    typedef enum logic [2:0] {S_IDLE, S_PAD, S_WEXP, S_ROUND, S_ADD, S_EMIT} t_state;

    t_state       r_state, r_ret;
    // Block buffer held as sixteen big-endian words, written one byte lane at a time.
    logic [31:0]  r_buf [16];
    logic [5:0]   r_fill;
    logic [63:0]  r_len, r_flen;
    logic         r_fin;
    logic [31:0]  r_h [8];
    logic [31:0]  r_v [8];
    logic [31:0]  r_w [16];
    logic [5:0]   r_rnd;
    logic [3:0]   r_ld;
    logic [2:0]   r_oi;
    logic [2:0]   r_oidx;
    logic         r_ovalid;
    logic [31:0]  r_oword;

    logic [7:0]   pad_byte;
    logic [31:0]  big1, big0, ch, maj, t1, t2, s0, s1, w_new, w_cur;
    logic         out_free;

    assign out_free = !r_ovalid || out_ch.ready;
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;

    // Length byte for the current fill position in the last block.
    always_comb begin
        pad_byte = '0;
        if (r_fill >= sha_pkg::LENGTH_POS)
            pad_byte = r_flen[8'd63 - {r_fill[2:0], 3'b000} -: 8];
    end

    // Round and schedule arithmetic.
    always_comb begin
        w_cur = r_w[0];
        s0 = sha_pkg::rotr(r_w[1], 7) ^ sha_pkg::rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = sha_pkg::rotr(r_w[14], 17) ^ sha_pkg::rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = r_w[0] + s0 + r_w[9] + s1;
        big1 = sha_pkg::rotr(r_v[4], 6) ^ sha_pkg::rotr(r_v[4], 11) ^
               sha_pkg::rotr(r_v[4], 25);
        ch   = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1   = r_v[7] + big1 + ch + sha_pkg::ROUND_K[r_rnd] + w_cur;
        big0 = sha_pkg::rotr(r_v[0], 2) ^ sha_pkg::rotr(r_v[0], 13) ^
               sha_pkg::rotr(r_v[0], 22);
        maj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2   = big0 + maj;
    end

    // Sequencer and datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_fill   <= '0;
            r_len    <= '0;
            r_fin    <= 1'b0;
            r_ovalid <= 1'b0;
            r_oi     <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::INIT_HASH[i];
        end else begin
            // The output word is valid from its load until the sink takes it.
            if (r_state == S_EMIT && out_free) r_ovalid <= 1'b1;
            else if (out_ch.ready) r_ovalid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.opcode == sha_pkg::OP_ABSORB) begin
                            r_buf[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= i_cmd.data_byte;
                            r_fill <= r_fill + 6'd1;
                            r_len  <= r_len + 64'd8;
                            r_fin  <= 1'b0;
                            if (r_fill == 6'd63) begin
                                r_state <= S_WEXP;
                                r_ret   <= S_IDLE;
                                r_ld    <= '0;
                            end
                        end else begin
                            r_buf[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <=
                                sha_pkg::PAD_BYTE;
                            r_fill <= r_fill + 6'd1;
                            r_flen <= r_len;
                            r_fin  <= 1'b1;
                            r_ld   <= '0;
                            r_state <= (r_fill == 6'd63) ? S_WEXP : S_PAD;
                            // A pad byte at position 55 leaves room for the length at once.
                            r_ret   <= (r_fill == 6'd55) ? S_EMIT : S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    if (r_fill == 6'd0 && r_ret == S_EMIT) begin
                        r_state <= S_EMIT;
                        r_oi    <= '0;
                    end else begin
                        r_buf[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <=
                            (r_ret == S_EMIT) ? pad_byte : 8'h00;
                        r_fill <= r_fill + 6'd1;
                        if (r_fill == 6'd55) r_ret <= S_EMIT;
                        if (r_fill == 6'd63) begin
                            r_state <= S_WEXP;
                            r_ld    <= '0;
                        end
                    end
                end
                S_WEXP: begin
                    // Load one schedule word per cycle from the buffer.
                    r_w[r_ld] <= r_buf[r_ld];
                    r_ld <= r_ld + 4'd1;
                    if (r_ld == 4'd15) begin
                        r_state <= S_ROUND;
                        r_rnd   <= '0;
                        for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    end
                end
                S_ROUND: begin
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
                    r_w[15] <= w_new;
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_state <= S_ADD;
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_state <= r_fin ? r_ret : S_IDLE;
                    r_oi <= '0;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_oword  <= r_h[r_oi];
                        r_oidx   <= r_oi;
                        r_oi     <= r_oi + 3'd1;
                        if (r_oi == 3'd7) begin
                            r_state <= S_IDLE;
                            r_len   <= '0;
                            r_fin   <= 1'b0;
                            for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::INIT_HASH[i];
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid       = r_ovalid;
    assign out_ch.digest_word = r_oword;
    assign out_ch.word_index  = r_oidx;
    assign out_ch.last        = (r_oidx == 3'd7);

`ifndef SYNTH
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> r_state == S_IDLE) else $error("pop outside idle");
    a_emit_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> r_fill == 6'd0) else $error("emit with data in buffer");
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_rnd == 6'd63) |=> r_state == S_ADD)
        else $error("round count slip");
`endif
endmodule
